// ----- hdl/npmr_pkg.sv -----
// Package for the next-prime Miller-Rabin search block.
// Shared constants, FSM state type and the status struct of the serial
// modular multiplier. No dependencies.
package npmr_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 31;
  localparam int unsigned BASE_W         = 31;
  localparam int unsigned CNT_W          = $clog2(BASE_W);
  localparam logic [BASE_W-1:0] BASE_RST = BASE_W'(2);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CAND,
    ST_RED,
    ST_TRIV,
    ST_SPLIT,
    ST_POW_CHK,
    ST_POW_MR,
    ST_POW_SQ,
    ST_POW_END,
    ST_SQ_CHK,
    ST_SQ_WAIT,
    ST_FAIL,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_status_t;

endpackage

// ----- hdl/npmr_mulmod.sv -----
// Bit-serial modular multiplier: prod = a * b mod n, one bit of b per cycle.
// Operands must be below n; n must hold while busy.
// Depends on npmr_pkg.
module npmr_mulmod #(
  parameter int unsigned DATA_WIDTH = npmr_pkg::DATA_WIDTH_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [DATA_WIDTH-1:0]   a_i,
  input  logic [DATA_WIDTH-1:0]   b_i,
  input  logic [DATA_WIDTH-1:0]   n_i,
  output logic [DATA_WIDTH-1:0]   prod_o,
  output npmr_pkg::mul_status_t   status_o
);

  logic                  busy_q, busy_d;
  logic [DATA_WIDTH-1:0] acc_q, acc_d;
  logic [DATA_WIDTH-1:0] a_q, a_d;
  logic [DATA_WIDTH-1:0] b_q, b_d;
  logic                  done;

  function automatic logic [DATA_WIDTH-1:0] add_mod(
    input logic [DATA_WIDTH-1:0] x,
    input logic [DATA_WIDTH-1:0] y,
    input logic [DATA_WIDTH-1:0] n
  );
    logic [DATA_WIDTH:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, n}) begin
      s = s - {1'b0, n};
    end
    return s[DATA_WIDTH-1:0];
  endfunction

  assign done = busy_q && (b_q == '0);

  always_comb begin
    busy_d = busy_q;
    acc_d  = acc_q;
    a_d    = a_q;
    b_d    = b_q;
    if (start_i) begin
      busy_d = 1'b1;
      acc_d  = '0;
      a_d    = a_i;
      b_d    = b_i;
    end else if (done) begin
      busy_d = 1'b0;
    end else if (busy_q) begin
      acc_d = b_q[0] ? add_mod(acc_q, a_q, n_i) : acc_q;
      a_d   = add_mod(a_q, a_q, n_i);
      b_d   = b_q >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
  end

  assign prod_o        = acc_q;
  assign status_o.busy = busy_q;
  assign status_o.done = done;

endmodule

// ----- hdl/next_prime_miller_rabin_top.sv -----
// Next probable prime search: one strong-probable-prime round per odd candidate.
// Starts of 0, 1 or all ones finish without a search; otherwise each odd
// candidate goes through base reduction, split of n-1, exponentiation and
// squarings, all products computed by the
// single bit-serial modular multiplier. One request at a time.
// Reset: async active low; idle, no result pending, witness base = 2.
module next_prime_miller_rabin_top #(
  parameter int unsigned DATA_WIDTH = npmr_pkg::DATA_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [DATA_WIDTH-1:0]       start_value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [DATA_WIDTH-1:0]       next_prime_o,
  input  logic                        cfg_we_i,
  input  logic [npmr_pkg::BASE_W-1:0] cfg_wdata_i
);

  localparam int unsigned SW = $clog2(DATA_WIDTH);

  npmr_pkg::state_e state_q, state_d;

  logic [npmr_pkg::BASE_W-1:0] base_q;
  logic                        out_valid_q;
  logic [DATA_WIDTH-1:0]       out_q;

  logic [DATA_WIDTH-1:0]       c_q;
  logic [DATA_WIDTH-1:0]       b_q;
  logic [DATA_WIDTH-1:0]       r_q;
  logic [DATA_WIDTH-1:0]       e_q;
  logic [SW-1:0]               s_q;
  logic [SW-1:0]               i_q;
  logic [npmr_pkg::BASE_W-1:0] bs_q;
  logic [npmr_pkg::CNT_W-1:0]  cnt_q;

  logic                        in_acc;
  logic                        out_load;
  logic [DATA_WIDTH-1:0]       nm1;
  logic [DATA_WIDTH:0]         red_tmp;
  logic                        red_ge;
  logic                        red_last;
  logic                        mul_start;
  logic [DATA_WIDTH-1:0]       mul_a;
  logic [DATA_WIDTH-1:0]       mul_b;
  logic [DATA_WIDTH-1:0]       prod;
  npmr_pkg::mul_status_t       mul_st;

  assign nm1      = c_q - DATA_WIDTH'(1);
  assign red_tmp  = {b_q, bs_q[npmr_pkg::BASE_W-1]};
  assign red_ge   = red_tmp >= {1'b0, c_q};
  assign red_last = cnt_q == npmr_pkg::CNT_W'(npmr_pkg::BASE_W - 1);
  assign in_acc   = in_valid_i && !in_stall_o;

  npmr_mulmod #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .n_i     (c_q),
    .prod_o  (prod),
    .status_o(mul_st)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      npmr_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (start_value_i <= DATA_WIDTH'(1) || (&start_value_i)) begin
            state_d = npmr_pkg::ST_FINISH;
          end else begin
            state_d = npmr_pkg::ST_CAND;
          end
        end
      end
      npmr_pkg::ST_CAND: begin
        if (c_q[0]) state_d = npmr_pkg::ST_RED;
      end
      npmr_pkg::ST_RED: begin
        if (red_last) state_d = npmr_pkg::ST_TRIV;
      end
      npmr_pkg::ST_TRIV: begin
        if (b_q == '0 || b_q == DATA_WIDTH'(1) || b_q == nm1) begin
          state_d = npmr_pkg::ST_FINISH;
        end else begin
          state_d = npmr_pkg::ST_SPLIT;
        end
      end
      npmr_pkg::ST_SPLIT: begin
        if (e_q[0]) state_d = npmr_pkg::ST_POW_CHK;
      end
      npmr_pkg::ST_POW_CHK: begin
        priority if (e_q == '0) state_d = npmr_pkg::ST_POW_END;
        else if (e_q[0])        state_d = npmr_pkg::ST_POW_MR;
        else                    state_d = npmr_pkg::ST_POW_SQ;
      end
      npmr_pkg::ST_POW_MR: begin
        if (mul_st.done) state_d = npmr_pkg::ST_POW_SQ;
      end
      npmr_pkg::ST_POW_SQ: begin
        if (mul_st.done) state_d = npmr_pkg::ST_POW_CHK;
      end
      npmr_pkg::ST_POW_END: begin
        if (r_q == DATA_WIDTH'(1) || r_q == nm1) begin
          state_d = npmr_pkg::ST_FINISH;
        end else begin
          state_d = npmr_pkg::ST_SQ_CHK;
        end
      end
      npmr_pkg::ST_SQ_CHK: begin
        if (i_q >= s_q) begin
          state_d = npmr_pkg::ST_FAIL;
        end else begin
          state_d = npmr_pkg::ST_SQ_WAIT;
        end
      end
      npmr_pkg::ST_SQ_WAIT: begin
        if (mul_st.done) begin
          priority if (prod == nm1)           state_d = npmr_pkg::ST_FINISH;
          else if (prod == DATA_WIDTH'(1))   state_d = npmr_pkg::ST_FAIL;
          else                                state_d = npmr_pkg::ST_SQ_CHK;
        end
      end
      npmr_pkg::ST_FAIL: begin
        if (&c_q) begin
          state_d = npmr_pkg::ST_FINISH;
        end else begin
          state_d = npmr_pkg::ST_CAND;
        end
      end
      npmr_pkg::ST_FINISH: begin
        if (out_load) state_d = npmr_pkg::ST_IDLE;
      end
      default: state_d = npmr_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall_o = (state_q != npmr_pkg::ST_IDLE);
    out_load   = (state_q == npmr_pkg::ST_FINISH) && (!out_valid_q || !out_stall_i);
    mul_start  = ((state_q == npmr_pkg::ST_POW_CHK) && (e_q != '0))
              || ((state_q == npmr_pkg::ST_POW_MR) && mul_st.done)
              || ((state_q == npmr_pkg::ST_SQ_CHK) && (i_q < s_q));
    mul_a      = ((state_q == npmr_pkg::ST_SQ_CHK)
              || ((state_q == npmr_pkg::ST_POW_CHK) && e_q[0])) ? r_q : b_q;
    mul_b      = (state_q == npmr_pkg::ST_SQ_CHK) ? r_q : b_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= npmr_pkg::ST_IDLE;
      base_q      <= npmr_pkg::BASE_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) base_q <= cfg_wdata_i;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (out_load) out_q <= c_q;
    unique case (state_q)
      npmr_pkg::ST_IDLE: begin
        if (in_acc) begin
          priority if (start_value_i <= DATA_WIDTH'(1)) c_q <= DATA_WIDTH'(2);
          else if (&start_value_i)                      c_q <= '0;
          else                                          c_q <= start_value_i + DATA_WIDTH'(1);
        end
      end
      npmr_pkg::ST_CAND: begin
        if (!c_q[0]) begin
          c_q <= c_q + DATA_WIDTH'(1);
        end else begin
          b_q   <= '0;
          bs_q  <= base_q;
          cnt_q <= '0;
        end
      end
      npmr_pkg::ST_RED: begin
        b_q   <= red_ge ? DATA_WIDTH'(red_tmp - {1'b0, c_q}) : red_tmp[DATA_WIDTH-1:0];
        bs_q  <= bs_q << 1;
        cnt_q <= cnt_q + npmr_pkg::CNT_W'(1);
      end
      npmr_pkg::ST_TRIV: begin
        e_q <= nm1;
        s_q <= '0;
        r_q <= DATA_WIDTH'(1);
      end
      npmr_pkg::ST_SPLIT: begin
        if (!e_q[0]) begin
          e_q <= e_q >> 1;
          s_q <= s_q + SW'(1);
        end
      end
      npmr_pkg::ST_POW_MR: begin
        if (mul_st.done) r_q <= prod;
      end
      npmr_pkg::ST_POW_SQ: begin
        if (mul_st.done) begin
          b_q <= prod;
          e_q <= e_q >> 1;
        end
      end
      npmr_pkg::ST_POW_END: begin
        i_q <= SW'(1);
      end
      npmr_pkg::ST_SQ_WAIT: begin
        if (mul_st.done) begin
          r_q <= prod;
          i_q <= i_q + SW'(1);
        end
      end
      npmr_pkg::ST_FAIL: begin
        c_q <= (&c_q) ? '0 : c_q + DATA_WIDTH'(1);
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign next_prime_o = out_q;

  a_mul_start_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start |-> (!mul_st.busy || mul_st.done))
    else $error("multiplier started while busy");

  a_result_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (next_prime_o[0] || next_prime_o == DATA_WIDTH'(2) || next_prime_o == '0))
    else $error("result neither odd, two nor zero");

  a_round_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == npmr_pkg::ST_SQ_CHK) |-> (r_q < c_q && b_q < c_q))
    else $error("round operand not reduced");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q != npmr_pkg::ST_IDLE))
    else $error("request accepted without starting a search");

endmodule

// ----- verif/tb_next_prime_miller_rabin_top.sv -----
// Testbench for next_prime_miller_rabin_top: drives start values and witness bases,
// and checks each next_prime result against a built-in strong-probable-prime search.
// Depends on npmr_pkg and the block's RTL only.
module tb_next_prime_miller_rabin_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DW = npmr_pkg::DATA_WIDTH_DEF;
  localparam int unsigned MAX_SHOWN = 10;
  localparam int unsigned CYCLE_LIMIT = 150_000_000;
  localparam int unsigned DRAIN_CYCLES = 4000;
  localparam int unsigned RAND_PHASES = 6;
  localparam int unsigned PHASE_ITEMS = 13;

  typedef logic [DW-1:0] value_t;
  typedef logic [npmr_pkg::BASE_W-1:0] base_t;
  typedef struct packed {
    value_t start;
    value_t prime;
  } prime_req_t;

  localparam value_t VAL_MAX = {DW{1'b1}};
  localparam base_t BASE_MAX = {npmr_pkg::BASE_W{1'b1}};

  class prime_scoreboard;
    base_t witness_base;
    prime_req_t expected_primes[$];
    int unsigned failures;

    function new();
      witness_base = npmr_pkg::BASE_RST;
      failures = 0;
    endfunction

    function void set_base(base_t b);
      witness_base = b;
    endfunction

    function int pending();
      return expected_primes.size();
    endfunction

    function longint unsigned pow_mod(longint unsigned b, longint unsigned e,
                                      longint unsigned n);
      longint unsigned r;
      r = 1;
      while (e != 0) begin
        if (e[0]) r = (r * b) % n;
        b = (b * b) % n;
        e >>= 1;
      end
      return r;
    endfunction

    // n odd, at least 3
    function bit strong_round_passes(longint unsigned n);
      longint unsigned a, d, x;
      int unsigned s;
      a = longint'(witness_base) % n;
      if (a == 0 || a == 1 || a == n - 1) return 1'b1;
      d = n - 1;
      s = 0;
      while (!d[0]) begin
        d >>= 1;
        s++;
      end
      x = pow_mod(a, d, n);
      if (x == 1 || x == n - 1) return 1'b1;
      for (int unsigned i = 1; i < s; i++) begin
        x = (x * x) % n;
        if (x == n - 1) return 1'b1;
        if (x == 1) return 1'b0;
      end
      return 1'b0;
    endfunction

    function value_t next_probable_prime(value_t start);
      longint unsigned cand;
      if (start <= 1) return value_t'(2);
      for (cand = longint'(start) + 1; cand <= longint'(VAL_MAX); cand++) begin
        if (cand[0] && strong_round_passes(cand)) return value_t'(cand);
      end
      return '0;
    endfunction

    function void note_request(value_t start);
      prime_req_t req;
      req.start = start;
      req.prime = next_probable_prime(start);
      expected_primes.push_back(req);
    endfunction

    function void check_prime(value_t got);
      prime_req_t req;
      if (expected_primes.size() == 0) begin
        failures++;
        if (failures <= MAX_SHOWN) $display("unexpected result %0d, no request pending", got);
        return;
      end
      req = expected_primes.pop_front();
      if (got !== req.prime) begin
        failures++;
        if (failures <= MAX_SHOWN)
          $display("mismatch: start %0d base %0d expected %0d got %0d",
                   req.start, witness_base, req.prime, got);
      end
    endfunction
  endclass

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   in_valid_i = 1'b0;
  logic   in_stall_o;
  value_t start_value_i = '0;
  logic   out_valid_o;
  logic   out_stall_i = 1'b0;
  value_t next_prime_o;
  logic   cfg_we_i = 1'b0;
  base_t  cfg_wdata_i = '0;

  int unsigned send_idle_pct = 19;
  int unsigned recv_stall_pct = 63;
  int unsigned cycle_count = 0;
  prime_scoreboard sb = new();

  next_prime_miller_rabin_top #(
    .DATA_WIDTH(DW)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .start_value_i(start_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .next_prime_o (next_prime_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    if (rst_ni) out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) sb.check_prime(next_prime_o);
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(input value_t v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    start_value_i <= v;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.note_request(v);
    @(negedge clk_i);
  endtask

  task automatic drain_requests();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  task automatic write_base(input base_t b);
    drain_requests();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= b;
    @(posedge clk_i);
    sb.set_base(b);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic value_t random_start();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 75) return value_t'($urandom_range(5000));
    if (pick < 90) return value_t'($urandom);
    return VAL_MAX - value_t'($urandom_range(40));
  endfunction

  function automatic base_t random_base(int unsigned phase);
    unique case (phase)
      1: return base_t'(2);
      2: return base_t'($urandom_range(100, 3));
      4: return BASE_MAX;
      default: return base_t'($urandom);
    endcase
  endfunction

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset base 2: small starts, strong and plain pseudoprimes, top of range
    send_request(value_t'(0));
    send_request(value_t'(1));
    send_request(value_t'(2));
    send_request(value_t'(3));
    send_request(value_t'(4));
    send_request(value_t'(340));
    send_request(value_t'(1104));
    send_request(value_t'(2046));
    send_request(VAL_MAX);
    send_request(VAL_MAX - value_t'(1));
    send_request(VAL_MAX - value_t'(2));
    send_request(value_t'(31'h5555_5555));
    send_request(value_t'(31'h2AAA_AAAA));

    // bases 0 and 1 pass every odd candidate; then the all-ones base and base 2 again
    write_base(base_t'(0));
    send_request(value_t'(9));
    send_request(VAL_MAX - value_t'(9));
    write_base(base_t'(1));
    send_request(value_t'(14));
    send_request(value_t'(1000));
    write_base(BASE_MAX);
    send_request(VAL_MAX - value_t'(1));
    send_request(VAL_MAX - value_t'(2));
    send_request(value_t'(100));
    write_base(base_t'(2));
    send_request(value_t'(3));

    for (int unsigned phase = 0; phase < RAND_PHASES; phase++) begin
      write_base(random_base(phase));
      unique case (phase / 2)
        0: begin
          send_idle_pct = 19;
          recv_stall_pct = 63;
        end
        1: begin
          send_idle_pct = 63;
          recv_stall_pct = 19;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (int unsigned k = 0; k < PHASE_ITEMS; k++) send_request(random_start());
    end

    drain_requests();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
